// File: src/wbi_pkg.sv
// Shared types and constants for the wavetable bilinear interpolator.
package wbi_pkg;

  // Fixed field widths
  localparam int PHASE_W = 27;
  localparam int MORPH_W = 17;
  localparam int LTAB_W  = 6;
  localparam int LIDX_W  = 11;
  localparam int NTAB_W  = 7;
  localparam int SIZE_W  = 4;
  localparam int CFG_W   = 7;
  localparam int CFG_AW  = 2;
  localparam int TF_W    = 16;

  localparam logic [MORPH_W-1:0] MORPH_ONE = 17'h10000;

  // Request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Register indexes
  localparam logic [CFG_AW-1:0] CFG_NUM_TABLES = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_SIZE_LOG2  = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_READY      = 2'd2;

  // Read slots of one interpolated sample: lower table floor/next, upper table floor/next
  typedef enum logic [3:0] {
    SLOT_A0 = 4'b0001,
    SLOT_A1 = 4'b0010,
    SLOT_B0 = 4'b0100,
    SLOT_B1 = 4'b1000
  } slot_t;

endpackage

// File: src/wbi_ram.sv
// Generic single-port synchronous RAM with registered read.
module wbi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    en,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                        wdata,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: src/wavetable_bilinear_interp.sv
// Wavetable oscillator bank with bilinear (phase x morph) interpolation.
// Throughput: one load beat per cycle while no read beat is busy and the queue has credit;
//   a read beat makes four table reads on the single port of the table RAM, and the next
//   beat is accepted as the last of those reads is issued.
// Reset (rst, synchronous): registers return to num_tables=1, table_size_log2=11,
//   table_ready=0; pipeline and output queue empty. Table RAM is not cleared.
module wavetable_bilinear_interp
  import wbi_pkg::*;
#(
  parameter int MAX_TABLES     = 64,
  parameter int MAX_TABLE_SIZE = 2048,
  parameter int SAMPLE_WIDTH   = 16,
  parameter int FRAC_BITS      = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           req_type,
  input  logic [LTAB_W-1:0]              load_table,
  input  logic [LIDX_W-1:0]              load_index,
  input  logic signed [SAMPLE_WIDTH-1:0] load_value,
  input  logic [PHASE_W-1:0]             phase,
  input  logic [MORPH_W-1:0]             morph,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] sample,
  // register writes
  input  logic                           cfg_we,
  input  logic [CFG_AW-1:0]              cfg_addr,
  input  logic [CFG_W-1:0]               cfg_data
);

  localparam int SW           = SAMPLE_WIDTH;
  localparam int DEPTH        = MAX_TABLES * MAX_TABLE_SIZE;
  localparam int ADDR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TBL_W        = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
  // log2 of the largest power of two that fits in MAX_TABLE_SIZE
  localparam int SIZE_LOG2_MAX = $clog2(MAX_TABLE_SIZE + 1) - 1;
  localparam int IDX_W        = SIZE_LOG2_MAX;
  localparam int TI_W         = MORPH_W + TBL_W;
  localparam int PW           = SW + FRAC_BITS + 2;   // phase lerp product
  localparam int TW           = SW + TF_W + 2;        // table lerp product
  localparam int QD           = 4;                    // output queue depth
  localparam int QA           = 2;
  localparam int CW           = 3;                    // counts 0..QD

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [NTAB_W-1:0] num_tables;
  logic [SIZE_W-1:0] table_size_log2;
  logic              table_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_tables      <= NTAB_W'(1);
      table_size_log2 <= SIZE_W'(11);
      table_ready     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_NUM_TABLES: num_tables      <= cfg_data[NTAB_W-1:0];
        CFG_SIZE_LOG2:  table_size_log2 <= cfg_data[SIZE_W-1:0];
        CFG_READY:      table_ready     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Request decode (accept cycle): table pair, morph fraction, entry pair
  // ---------------------------------------------------------------------------
  logic [8:0]          nt_raw, nt_c;
  logic [TBL_W-1:0]    last;
  logic [MORPH_W-1:0]  morph_c;
  logic [TI_W-1:0]     ti;
  logic [TBL_W:0]      t0_raw;
  logic [TBL_W-1:0]    t0, t1;
  logic [TF_W-1:0]     tf;
  logic [4:0]          l_raw, l_c;
  logic [31:0]         mask32, int32, p0_32, p1_32;
  logic [31:0]         waddr32;
  logic                we_ok;

  always_comb begin
    nt_raw = {2'b00, num_tables};
    if (nt_raw == 9'd0) begin
      nt_c = 9'd1;
    end else if (nt_raw > 9'(MAX_TABLES)) begin
      nt_c = 9'(MAX_TABLES);
    end else begin
      nt_c = nt_raw;
    end
    last    = TBL_W'(nt_c - 9'd1);
    morph_c = (morph > MORPH_ONE) ? MORPH_ONE : morph;
    ti      = TI_W'(morph_c) * TI_W'(last);
    t0_raw  = ti[TI_W-1:TF_W];
    t0      = (t0_raw > {1'b0, last}) ? last : t0_raw[TBL_W-1:0];
    t1      = (t0 == last) ? last : TBL_W'(t0 + 1'b1);
    tf      = ti[TF_W-1:0];

    l_raw = {1'b0, table_size_log2};
    if (l_raw == 5'd0) begin
      l_c = 5'd1;
    end else if (l_raw > 5'(SIZE_LOG2_MAX)) begin
      l_c = 5'(SIZE_LOG2_MAX);
    end else begin
      l_c = l_raw;
    end
    mask32 = (32'd1 << l_c) - 32'd1;
    int32  = 32'(phase[PHASE_W-1:FRAC_BITS]);
    p0_32  = int32 & mask32;
    p1_32  = (p0_32 + 32'd1) & mask32;

    waddr32 = 32'(load_table) * MAX_TABLE_SIZE + 32'(load_index);
    we_ok   = (32'(load_table) < MAX_TABLES) && (32'(load_index) < MAX_TABLE_SIZE);
  end

  // ---------------------------------------------------------------------------
  // Sequencer: holds one beat, drives the RAM port one access per cycle
  // ---------------------------------------------------------------------------
  logic                    busy;
  slot_t                   slot;
  logic                    s_load, s_we, s_zero;
  logic [TBL_W-1:0]        s_ta, s_tb;
  logic [IDX_W-1:0]        s_p0, s_p1;
  logic [FRAC_BITS-1:0]    s_pf;
  logic [TF_W-1:0]         s_tf;
  logic [ADDR_W-1:0]       s_waddr;
  logic signed [SW-1:0]    s_wdata;

  logic [CW-1:0]           in_flight, q_count;
  logic                    credit_ok, seq_last, seq_take, read_take, push, pop;

  assign credit_ok = ({1'b0, in_flight} + {1'b0, q_count}) < (CW + 1)'(QD);
  assign seq_last  = busy && (s_load || (slot == SLOT_B1));
  assign in_ready  = (!busy || seq_last) && credit_ok;
  assign seq_take  = in_valid && in_ready;
  assign read_take = seq_take && (req_type == REQ_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      slot <= SLOT_A0;
    end else if (seq_take) begin
      busy <= 1'b1;
      slot <= SLOT_A0;
    end else if (seq_last) begin
      busy <= 1'b0;
    end else if (busy) begin
      unique case (slot)
        SLOT_A0: slot <= SLOT_A1;
        SLOT_A1: slot <= SLOT_B0;
        SLOT_B0: slot <= SLOT_B1;
        SLOT_B1: slot <= SLOT_A0;
        default: slot <= SLOT_A0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (seq_take) begin
      s_load  <= (req_type == REQ_LOAD);
      s_we    <= we_ok;
      s_zero  <= !table_ready;
      s_ta    <= t0;
      s_tb    <= t1;
      s_p0    <= p0_32[IDX_W-1:0];
      s_p1    <= p1_32[IDX_W-1:0];
      s_pf    <= phase[FRAC_BITS-1:0];
      s_tf    <= tf;
      s_waddr <= waddr32[ADDR_W-1:0];
      s_wdata <= load_value;
    end
  end

  // RAM address select for the current read slot
  logic [TBL_W-1:0]  t_sel;
  logic [IDX_W-1:0]  p_sel;
  logic [31:0]       raddr32;
  logic [ADDR_W-1:0] ram_addr;
  logic              ram_we;
  logic [SW-1:0]     ram_rdata;

  always_comb begin
    unique case (slot)
      SLOT_A0: begin t_sel = s_ta; p_sel = s_p0; end
      SLOT_A1: begin t_sel = s_ta; p_sel = s_p1; end
      SLOT_B0: begin t_sel = s_tb; p_sel = s_p0; end
      SLOT_B1: begin t_sel = s_tb; p_sel = s_p1; end
      default: begin t_sel = s_ta; p_sel = s_p0; end
    endcase
    raddr32  = 32'(t_sel) * MAX_TABLE_SIZE + 32'(p_sel);
    ram_addr = s_load ? s_waddr : raddr32[ADDR_W-1:0];
    ram_we   = busy && s_load && s_we;
  end

  wbi_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_table_ram (
    .clk   (clk),
    .en    (busy),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (s_wdata),
    .rdata (ram_rdata)
  );

  // Read data tag: which slot the RAM output belongs to
  logic  rv_valid;
  slot_t rv_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      rv_valid <= 1'b0;
      rv_slot  <= SLOT_A0;
    end else begin
      rv_valid <= busy && !s_load;
      rv_slot  <= slot;
    end
  end

  // ---------------------------------------------------------------------------
  // Interpolation datapath
  // phase lerp on the lower table while upper-table reads are in flight,
  // then the upper table, then the lerp across tables.
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0]   rd_s;
  logic signed [SW-1:0]   a0, b0, lo, hi, lo2, lo3;
  logic [FRAC_BITS-1:0]   pf_r;
  logic [TF_W-1:0]        tf_r, tf2;
  logic                   zero_r, zero2, zero3;
  logic signed [PW-1:0]   prod_lo, prod_hi;
  logic signed [TW-1:0]   prod_t;
  logic                   e1_v, e2_v, e3_v;

  logic signed [SW:0]     diff_rd_a, diff_rd_b, diff_t;
  logic signed [PW-1:0]   rnd_lo, rnd_hi;
  logic signed [TW-1:0]   rnd_t;
  logic signed [SW+1:0]   lo_sum, hi_sum, s_sum;
  logic signed [SW-1:0]   s_sat;

  localparam logic signed [SW+1:0] SMAX = (SW + 2)'((1 << (SW - 1)) - 1);
  localparam logic signed [SW+1:0] SMIN = -(SW + 2)'(1 << (SW - 1));

  always_comb begin
    rd_s      = $signed(ram_rdata);
    diff_rd_a = $signed({rd_s[SW-1], rd_s}) - $signed({a0[SW-1], a0});
    diff_rd_b = $signed({rd_s[SW-1], rd_s}) - $signed({b0[SW-1], b0});
    diff_t    = $signed({hi[SW-1], hi}) - $signed({lo2[SW-1], lo2});

    // round half up, arithmetic shift gives floor
    rnd_lo = (prod_lo + $signed(PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    rnd_hi = (prod_hi + $signed(PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    rnd_t  = (prod_t + $signed(TW'(1) <<< (TF_W - 1))) >>> TF_W;

    lo_sum = $signed({{2{a0[SW-1]}}, a0}) + $signed(rnd_lo[SW+1:0]);
    hi_sum = $signed({{2{b0[SW-1]}}, b0}) + $signed(rnd_hi[SW+1:0]);
    s_sum  = $signed({{2{lo3[SW-1]}}, lo3}) + $signed(rnd_t[SW+1:0]);

    if (zero3) begin
      s_sat = '0;
    end else if (s_sum > SMAX) begin
      s_sat = SMAX[SW-1:0];
    end else if (s_sum < SMIN) begin
      s_sat = SMIN[SW-1:0];
    end else begin
      s_sat = s_sum[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_v <= 1'b0;
      e2_v <= 1'b0;
      e3_v <= 1'b0;
    end else begin
      e1_v <= rv_valid && (rv_slot == SLOT_B1);
      e2_v <= e1_v;
      e3_v <= e2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rv_valid) begin
      unique case (rv_slot)
        SLOT_A0: begin
          a0     <= rd_s;
          pf_r   <= s_pf;
          tf_r   <= s_tf;
          zero_r <= s_zero;
        end
        SLOT_A1: prod_lo <= PW'(diff_rd_a * $signed({1'b0, pf_r}));
        SLOT_B0: begin
          b0 <= rd_s;
          lo <= lo_sum[SW-1:0];
        end
        SLOT_B1: prod_hi <= PW'(diff_rd_b * $signed({1'b0, pf_r}));
        default: ;
      endcase
    end
    if (e1_v) begin
      hi    <= hi_sum[SW-1:0];
      lo2   <= lo;
      tf2   <= tf_r;
      zero2 <= zero_r;
    end
    if (e2_v) begin
      prod_t <= TW'(diff_t * $signed({1'b0, tf2}));
      lo3    <= lo2;
      zero3  <= zero2;
    end
  end

  // ---------------------------------------------------------------------------
  // Output queue; credit check at accept keeps it from overflowing
  // ---------------------------------------------------------------------------
  logic [SW-1:0] q_mem [QD];
  logic [QA-1:0] q_head, q_tail;

  assign push      = e3_v;
  assign out_valid = (q_count != '0);
  assign pop       = out_valid && out_ready;
  assign sample    = $signed(q_mem[q_head]);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_head    <= '0;
      q_tail    <= '0;
      q_count   <= '0;
      in_flight <= '0;
    end else begin
      if (push) begin
        q_tail <= q_tail + 1'b1;
      end
      if (pop) begin
        q_head <= q_head + 1'b1;
      end
      q_count   <= q_count + CW'(push) - CW'(pop);
      in_flight <= in_flight + CW'(read_take) - CW'(push);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[q_tail] <= s_sat;
    end
  end

endmodule
